[hdl/dbpc_pkg.sv]
package dbpc_pkg;

    // Event ring geometry
    localparam int RING_DEPTH = 4;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    // Fixed field widths
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int CODE_W = 2;
    localparam int OP_W   = 2;
    localparam int FILL_W = 3;
    localparam int IDX_W  = 2;

    // Reset values of the timing registers (ms)
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd750;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_LONG_PRESS = 2'd1;

    // Operations
    localparam logic [OP_W-1:0] OP_POLL   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_INJECT = 2'd2;

    // Event codes
    localparam logic [CODE_W-1:0] CODE_NEXT_SHORT   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_NEXT_LONG    = 2'd1;
    localparam logic [CODE_W-1:0] CODE_SELECT_SHORT = 2'd2;

    // Event produced by one button lane on a poll
    typedef struct packed {
        logic              push;
        logic [CODE_W-1:0] code;
    } lane_evt_t;

    // Ring requests for one word, pushes in order a then b
    typedef struct packed {
        logic              push_a;
        logic [CODE_W-1:0] code_a;
        logic              push_b;
        logic [CODE_W-1:0] code_b;
        logic              pop;
    } ring_req_t;

    // Ring response for the same word
    typedef struct packed {
        logic              pop_valid;
        logic [CODE_W-1:0] pop_code;
        logic [CNT_W-1:0]  fill;
    } ring_rsp_t;

    // Result word held in the output buffer
    typedef struct packed {
        logic              event_valid;
        logic [CODE_W-1:0] event_code;
        logic [FILL_W-1:0] queue_fill;
        logic              next_held;
        logic              select_held;
    } result_t;

    // Ring pointer advance with wrap at RING_DEPTH
    function automatic logic [RING_AW-1:0] ptr_inc(input logic [RING_AW-1:0] p);
        logic [RING_AW-1:0] r;
        if (p == RING_AW'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

[hdl/dbpc_lane.sv]
// One button: debounce and press classification
module dbpc_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick,
    input  logic [dbpc_pkg::TIME_W-1:0]   now_time,
    input  logic                          raw,
    input  logic                          has_long,
    input  logic [dbpc_pkg::CODE_W-1:0]   short_code,
    input  logic [dbpc_pkg::CFG_W-1:0]    debounce_time,
    input  logic [dbpc_pkg::CFG_W-1:0]    long_press_time,
    output logic                          stable_next,
    output dbpc_pkg::lane_evt_t           evt
);

    logic                        raw_reg;
    logic                        raw_next;
    logic                        stable_reg;
    logic                        long_done_reg;
    logic                        long_done_next;
    logic [dbpc_pkg::TIME_W-1:0] flip_time_reg;
    logic [dbpc_pkg::TIME_W-1:0] flip_time_next;
    logic [dbpc_pkg::TIME_W-1:0] press_time_reg;
    logic [dbpc_pkg::TIME_W-1:0] press_time_next;

    logic [dbpc_pkg::TIME_W-1:0] since_flip;
    logic [dbpc_pkg::TIME_W-1:0] held;
    logic                        settled;
    logic                        confirm_press;
    logic                        long_reached;

    // Time since last raw flip and hold time, both wrap mod 2^32
    assign flip_time_next = (tick && (raw != raw_reg)) ? now_time : flip_time_reg;
    assign since_flip     = now_time - flip_time_next;
    assign settled        = since_flip >= {{(dbpc_pkg::TIME_W - dbpc_pkg::CFG_W){1'b0}},
                                           debounce_time};
    assign held           = now_time - press_time_reg;

    // Next state and event
    always_comb begin
        raw_next        = raw_reg;
        stable_next     = stable_reg;
        long_done_next  = long_done_reg;
        press_time_next = press_time_reg;
        confirm_press   = 1'b0;
        long_reached    = 1'b0;
        evt             = '0;
        if (tick) begin
            raw_next = raw;
            if (settled) begin
                if (raw != stable_reg) begin
                    stable_next = raw;
                    if (raw) begin
                        press_time_next = now_time;
                        long_done_next  = 1'b0;
                        confirm_press   = 1'b1;
                    end else begin
                        if (!long_done_reg) begin
                            evt.push = 1'b1;
                            if (has_long && (held >= {{(dbpc_pkg::TIME_W - dbpc_pkg::CFG_W){1'b0}},
                                                      long_press_time})) begin
                                evt.code = dbpc_pkg::CODE_NEXT_LONG;
                            end else begin
                                evt.code = short_code;
                            end
                        end
                        press_time_next = '0;
                        long_done_next  = 1'b0;
                    end
                end
                // hold reaching the long threshold while still pressed
                if (confirm_press) begin
                    long_reached = (long_press_time == '0);
                end else begin
                    long_reached = held >= {{(dbpc_pkg::TIME_W - dbpc_pkg::CFG_W){1'b0}},
                                            long_press_time};
                end
                if (stable_next && !long_done_next && has_long && long_reached) begin
                    evt.push       = 1'b1;
                    evt.code       = dbpc_pkg::CODE_NEXT_LONG;
                    long_done_next = 1'b1;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            raw_reg        <= 1'b0;
            stable_reg     <= 1'b0;
            long_done_reg  <= 1'b0;
            flip_time_reg  <= '0;
            press_time_reg <= '0;
        end else begin
            raw_reg        <= raw_next;
            stable_reg     <= stable_next;
            long_done_reg  <= long_done_next;
            flip_time_reg  <= flip_time_next;
            press_time_reg <= press_time_next;
        end
    end

`ifndef SYNTHESIS
    // a long event is only ever marked during a debounced press
    assert property (@(posedge clk) disable iff (!rst_n) long_done_reg |-> stable_reg)
        else $error("lane: long_done set while released");
`endif

endmodule

[hdl/dbpc_ring.sv]
// Event ring: merges lane events and inject requests, serves pops
module dbpc_ring (
    input  logic                clk,
    input  logic                rst_n,
    input  dbpc_pkg::ring_req_t req,
    output dbpc_pkg::ring_rsp_t rsp
);

    logic [dbpc_pkg::CODE_W-1:0]  ring_mem_reg [dbpc_pkg::RING_DEPTH];
    logic [dbpc_pkg::RING_AW-1:0] head_reg;
    logic [dbpc_pkg::RING_AW-1:0] head_next;
    logic [dbpc_pkg::RING_AW-1:0] tail_reg;
    logic [dbpc_pkg::RING_AW-1:0] tail_next;
    logic [dbpc_pkg::CNT_W-1:0]   count_reg;
    logic [dbpc_pkg::CNT_W-1:0]   count_next;

    logic                         wr_a;
    logic                         wr_b;
    logic [dbpc_pkg::RING_AW-1:0] tail_a;
    logic [dbpc_pkg::CNT_W-1:0]   count_a;
    logic                         do_pop;

    localparam logic [dbpc_pkg::CNT_W-1:0] FULL = dbpc_pkg::CNT_W'(dbpc_pkg::RING_DEPTH);

    // First push, then second push on what the first left; full drops
    assign wr_a    = req.push_a && (count_reg != FULL);
    assign tail_a  = wr_a ? dbpc_pkg::ptr_inc(tail_reg) : tail_reg;
    assign count_a = wr_a ? count_reg + 1'b1 : count_reg;
    assign wr_b    = req.push_b && (count_a != FULL);
    assign do_pop  = req.pop && (count_reg != '0);

    always_comb begin
        tail_next  = wr_b ? dbpc_pkg::ptr_inc(tail_a) : tail_a;
        head_next  = do_pop ? dbpc_pkg::ptr_inc(head_reg) : head_reg;
        count_next = wr_b ? count_a + 1'b1 : count_a;
        if (do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Response for this word
    assign rsp.pop_valid = do_pop;
    assign rsp.pop_code  = do_pop ? ring_mem_reg[head_reg] : dbpc_pkg::CODE_NEXT_SHORT;
    assign rsp.fill      = count_next;

    // Entry storage, no reset
    always_ff @(posedge clk) begin
        for (int i = 0; i < dbpc_pkg::RING_DEPTH; i++) begin
            if (wr_a && (tail_reg == dbpc_pkg::RING_AW'(i))) begin
                ring_mem_reg[i] <= req.code_a;
            end else if (wr_b && (tail_a == dbpc_pkg::RING_AW'(i))) begin
                ring_mem_reg[i] <= req.code_b;
            end
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL)
        else $error("ring: count above depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != FULL) |-> (head_reg == tail_reg) == (count_reg == '0))
        else $error("ring: pointers disagree with count");
`endif

endmodule

[hdl/two_button_debounce_press_classifier_core.sv]
// Each accepted word's result is registered in the output register, or the skid when stalled.
// Throughput: one word per cycle while in_ready is high; both buttons run side by side.
// A two-word output buffer lets one more word in while a result waits to be taken.
// Reset (rst_n, async, active low) clears button state, ring pointers and the output
// buffer, and sets debounce_time to 20 ms and long_press_time to 750 ms.
module two_button_debounce_press_classifier_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // input words
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dbpc_pkg::OP_W-1:0]    op,
    input  logic [dbpc_pkg::TIME_W-1:0]  now_time,
    input  logic                         raw_next,
    input  logic                         raw_select,
    input  logic [dbpc_pkg::CODE_W-1:0]  inject_code,
    // result words
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         event_valid,
    output logic [dbpc_pkg::CODE_W-1:0]  event_code,
    output logic [dbpc_pkg::FILL_W-1:0]  queue_fill,
    output logic                         next_held,
    output logic                         select_held,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dbpc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [dbpc_pkg::CFG_W-1:0]   cfg_data
);

    logic [dbpc_pkg::CFG_W-1:0] debounce_reg;
    logic [dbpc_pkg::CFG_W-1:0] long_press_reg;

    logic                acc;
    logic                tick;
    logic                next_stable;
    logic                select_stable;
    dbpc_pkg::lane_evt_t next_evt;
    dbpc_pkg::lane_evt_t select_evt;
    dbpc_pkg::ring_req_t req;
    dbpc_pkg::ring_rsp_t rsp;
    dbpc_pkg::result_t   res;

    logic                out_valid_reg;
    dbpc_pkg::result_t   out_reg;
    logic                skid_valid_reg;
    dbpc_pkg::result_t   skid_reg;
    logic                take;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            debounce_reg   <= dbpc_pkg::DEBOUNCE_RST;
            long_press_reg <= dbpc_pkg::LONG_PRESS_RST;
        end else if (cfg_valid) begin
            if (cfg_index == dbpc_pkg::REG_DEBOUNCE) begin
                debounce_reg <= cfg_data;
            end else if (cfg_index == dbpc_pkg::REG_LONG_PRESS) begin
                long_press_reg <= cfg_data;
            end
        end
    end

    // Input handshake
    assign in_ready = !skid_valid_reg;
    assign acc      = in_valid && in_ready;
    assign tick     = acc && (op == dbpc_pkg::OP_POLL);

    // Button lanes
    dbpc_lane u_lane_next (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick            (tick),
        .now_time        (now_time),
        .raw             (raw_next),
        .has_long        (1'b1),
        .short_code      (dbpc_pkg::CODE_NEXT_SHORT),
        .debounce_time   (debounce_reg),
        .long_press_time (long_press_reg),
        .stable_next     (next_stable),
        .evt             (next_evt)
    );

    dbpc_lane u_lane_select (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick            (tick),
        .now_time        (now_time),
        .raw             (raw_select),
        .has_long        (1'b0),
        .short_code      (dbpc_pkg::CODE_SELECT_SHORT),
        .debounce_time   (debounce_reg),
        .long_press_time (long_press_reg),
        .stable_next     (select_stable),
        .evt             (select_evt)
    );

    // Merge: next lane first, then select lane, or the injected code
    always_comb begin
        req = '0;
        if (acc) begin
            unique case (op)
                dbpc_pkg::OP_POLL: begin
                    req.push_a = next_evt.push;
                    req.code_a = next_evt.code;
                    req.push_b = select_evt.push;
                    req.code_b = select_evt.code;
                end
                dbpc_pkg::OP_POP: begin
                    req.pop = 1'b1;
                end
                dbpc_pkg::OP_INJECT: begin
                    req.push_a = 1'b1;
                    req.code_a = inject_code;
                end
                default: begin
                    req = '0;
                end
            endcase
        end
    end

    dbpc_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Result word
    assign res.event_valid = rsp.pop_valid;
    assign res.event_code  = rsp.pop_code;
    assign res.queue_fill  = dbpc_pkg::FILL_W'(rsp.fill);
    assign res.next_held   = next_stable;
    assign res.select_held = select_stable;

    // Output register with skid stage
    assign take = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (take || !out_valid_reg) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= acc;
                end
            end else if (acc) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (take || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (acc) begin
                out_reg <= res;
            end
        end else if (acc) begin
            skid_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = out_reg.event_valid;
    assign event_code  = out_reg.event_code;
    assign queue_fill  = out_reg.queue_fill;
    assign next_held   = out_reg.next_held;
    assign select_held = out_reg.select_held;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> out_valid_reg)
        else $error("core: skid word without output word");
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("core: word accepted under stall not held in skid");
`endif

endmodule
